// ===== rtl/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// shs_pkg: shared types, constants and functions of the SHA-256 stream hasher
// Holds the round constants, the initial hash value, the sigma functions and
// the control bundle between the sequencer and the message schedule.
// ----------------------------------------------------------------------------
package shs_pkg;

    typedef logic [7:0][31:0] shs_hash_t;

    typedef struct packed {
        logic byte_shift;
        logic word_shift;
    } shs_sched_ctrl_t;

    localparam shs_hash_t HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_SLOT = 6'd63;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== rtl/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher: SHA-256 over a byte stream, digest in four beats
// A byte beat that completes a 64-byte block starts a compression: a load,
//   64 rounds of the shared round unit and a fold.
// End beat: byte-wise padding plus one or two compressions, then four
//   result beats, one per cycle when m_ready is high.
// Throughput: one beat at a time; s_ready is low while padding, compressing
//   or emitting. Reset (synchronous, aresetn low) loads the initial hash.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_message_byte,
    input  logic        s_byte_present,
    input  logic        s_message_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_word,
    output logic [1:0]  m_word_number,
    output logic        m_final_word
);
    import shs_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // take message beats
    localparam logic [1:0] S_PAD  = 2'd1;  // shift in 0x80, zeros and length
    localparam logic [1:0] S_COMP = 2'd2;  // wait on the round unit
    localparam logic [1:0] S_OUT  = 2'd3;  // emit four digest beats

    logic [1:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] total_reg, total_next;
    logic        pad_active_reg, pad_active_next;  // end seen, padding pending
    logic        pad_mark_reg, pad_mark_next;      // 0x80 still to be placed
    logic        len_ok_reg, len_ok_next;          // this block takes the length
    logic        final_reg, final_next;            // compression ends the message
    logic [1:0]  word_reg, word_next;

    shs_sched_ctrl_t sched_ctrl;
    logic [7:0]      sched_byte;
    logic [31:0]     w_cur;
    logic            comp_start;
    logic            core_init;
    logic            round_active;
    logic            core_done;
    shs_hash_t       hash_words;

    logic s_beat;
    logic m_beat;
    logic len_phase;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign s_beat  = s_valid && s_ready;
    assign m_beat  = m_valid && m_ready;

    // digest words come straight from the chaining registers, stable in S_OUT
    assign m_digest_word = {hash_words[{word_reg, 1'b0}], hash_words[{word_reg, 1'b1}]};
    assign m_word_number = word_reg;
    assign m_final_word  = (word_reg == 2'd3);

    // length bytes go into slots 56..63 of the last block only
    assign len_phase = !pad_mark_reg && len_ok_reg && (fill_reg >= LEN_START);

    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        total_next      = total_reg;
        pad_active_next = pad_active_reg;
        pad_mark_next   = pad_mark_reg;
        len_ok_next     = len_ok_reg;
        final_next      = final_reg;
        word_next       = word_reg;
        sched_byte      = s_message_byte;
        sched_ctrl      = '{byte_shift: 1'b0, word_shift: round_active};
        comp_start      = 1'b0;
        core_init       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_beat) begin
                    if (s_message_end) begin
                        pad_active_next = 1'b1;
                        pad_mark_next   = 1'b1;
                        state_next      = S_PAD;
                    end
                    if (s_byte_present) begin
                        sched_ctrl.byte_shift = 1'b1;
                        fill_next  = fill_reg + 6'd1;
                        total_next = total_reg + 64'd8;
                        // full block: compress before anything else
                        if (fill_reg == LAST_SLOT) begin
                            comp_start = 1'b1;
                            state_next = S_COMP;
                        end
                    end
                end
            end
            S_PAD: begin
                sched_ctrl.byte_shift = 1'b1;
                fill_next = fill_reg + 6'd1;
                if (pad_mark_reg) begin
                    sched_byte    = PAD_MARK;
                    pad_mark_next = 1'b0;
                    // no room for the length after the mark: spill a block
                    len_ok_next   = (fill_reg < LEN_START);
                end else if (len_phase) begin
                    sched_byte = total_reg[63:56];
                    total_next = {total_reg[55:0], 8'h00};
                end else begin
                    sched_byte = 8'h00;
                end
                if (fill_reg == LAST_SLOT) begin
                    comp_start = 1'b1;
                    state_next = S_COMP;
                    final_next = len_phase;
                    if (!len_phase) begin
                        len_ok_next = 1'b1;
                    end
                end
            end
            S_COMP: begin
                if (core_done) begin
                    priority if (final_reg) begin
                        state_next = S_OUT;
                    end else if (pad_active_reg) begin
                        state_next = S_PAD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (m_beat) begin
                    word_next = word_reg + 2'd1;
                    if (m_final_word) begin
                        // restart for the next message
                        core_init       = 1'b1;
                        fill_next       = '0;
                        total_next      = '0;
                        pad_active_next = 1'b0;
                        pad_mark_next   = 1'b0;
                        len_ok_next     = 1'b0;
                        final_next      = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            total_reg      <= '0;
            pad_active_reg <= 1'b0;
            pad_mark_reg   <= 1'b0;
            len_ok_reg     <= 1'b0;
            final_reg      <= 1'b0;
            word_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            total_reg      <= total_next;
            pad_active_reg <= pad_active_next;
            pad_mark_reg   <= pad_mark_next;
            len_ok_reg     <= len_ok_next;
            final_reg      <= final_next;
            word_reg       <= word_next;
        end
    end

    shs_msg_sched u_sched (
        .aclk    (aclk),
        .ctrl    (sched_ctrl),
        .byte_in (sched_byte),
        .w_cur   (w_cur)
    );

    shs_round_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (comp_start),
        .init         (core_init),
        .w_cur        (w_cur),
        .round_active (round_active),
        .done         (core_done),
        .hash_words   (hash_words)
    );

endmodule

// ===== rtl/shs_msg_sched.sv =====
// ----------------------------------------------------------------------------
// shs_msg_sched: block buffer and rolling message schedule
// A 16-word shift line: bytes shift in while a block fills, then each round
// shifts out the current schedule word and appends the expanded one.
// ----------------------------------------------------------------------------
module shs_msg_sched (
    input  logic                     aclk,
    input  shs_pkg::shs_sched_ctrl_t ctrl,
    input  logic [7:0]               byte_in,
    output logic [31:0]              w_cur
);
    import shs_pkg::*;

    logic [15:0][31:0] blk_reg;
    logic [15:0][31:0] blk_next;
    logic [31:0]       w_new;

    // word 15 is the oldest, i.e. the next one consumed
    assign w_cur = blk_reg[15];
    assign w_new = small_sigma1(blk_reg[1]) + blk_reg[6]
                 + small_sigma0(blk_reg[14]) + blk_reg[15];

    always_comb begin
        blk_next = blk_reg;
        if (ctrl.byte_shift) begin
            blk_next = {blk_reg[15][23:0], blk_reg[14:0], byte_in};
        end else if (ctrl.word_shift) begin
            blk_next = {blk_reg[14:0], w_new};
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
    end

endmodule

// ===== rtl/shs_round_core.sv =====
// ----------------------------------------------------------------------------
// shs_round_core: shared SHA-256 round unit and chaining value
// Runs one round per cycle up to the last round, then folds the working
// variables into the hash words.
// ----------------------------------------------------------------------------
module shs_round_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              init,
    input  logic [31:0]       w_cur,
    output logic              round_active,
    output logic              done,
    output shs_pkg::shs_hash_t hash_words
);
    import shs_pkg::*;

    shs_hash_t  h_reg;
    shs_hash_t  v_reg;
    shs_hash_t  v_next;
    logic       run_reg;
    logic       fold_reg;
    logic [5:0] round_reg;
    logic [31:0] t1;
    logic [31:0] t2;

    assign round_active = run_reg;
    assign done         = fold_reg;
    assign hash_words   = h_reg;

    always_comb begin
        t1 = v_reg[7] + big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + ROUND_K[round_reg] + w_cur;
        t2 = big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        v_next = {v_reg[6:4], v_reg[3] + t1, v_reg[2:0], t1 + t2};
    end

    // working variables: payload only
    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg <= h_reg;
        end else if (run_reg) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            fold_reg  <= 1'b0;
            round_reg <= '0;
            h_reg     <= HASH_IV;
        end else begin
            fold_reg <= 1'b0;
            if (start) begin
                run_reg   <= 1'b1;
                round_reg <= '0;
            end else if (run_reg) begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == LAST_SLOT) begin
                    run_reg  <= 1'b0;
                    fold_reg <= 1'b1;
                end
            end
            if (fold_reg) begin
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (init) begin
                h_reg <= HASH_IV;
            end
        end
    end

endmodule
